// ----- sv/mmis_pkg.sv -----
// ----------------------------------------------------------------------------
// mmis_pkg
// Shared widths, register codes, types and helpers of the multinomial mode
// isotope shift unit.
// ----------------------------------------------------------------------------
package mmis_pkg;

    // field and register widths
    localparam int NumSlots  = 4;
    localparam int IdxW      = 2;
    localparam int IsoW      = 3;
    localparam int AtomW     = 12;
    localparam int CountW    = 12;
    localparam int ProbW     = 25;
    localparam int DeltaW    = 28;
    localparam int FracBits  = 24;
    localparam int ExactW    = 40;
    localparam int NomW      = 16;

    // shared multiplier and accumulators
    localparam int MulAW     = DeltaW;
    localparam int MulBW     = CountW + 1;
    localparam int ProdW     = MulAW + MulBW;
    localparam int KeyW      = ProbW + MulBW;
    localparam int ExactAccW = ExactW + 2;
    localparam int NomAccW   = NomW + 2;
    localparam int RoundW    = DeltaW + 1 - FracBits;

    // stream and apb widths
    localparam int SDataW    = 16;
    localparam int MDataW    = NumSlots * CountW + ExactW + NomW;
    localparam int CfgAddrW  = 5;
    localparam int CfgDataW  = 32;

    // reset values
    localparam logic [IsoW-1:0]  IsoCountReset = IsoW'(2);
    localparam logic [ProbW-1:0] ProbOne       = ProbW'(1) << FracBits;

    // register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_ISOTOPE_COUNT = 3'd0,
        REG_PROB_0        = 3'd1,
        REG_PROB_1        = 3'd2,
        REG_PROB_2        = 3'd3,
        REG_PROB_3        = 3'd4,
        REG_DELTA_1       = 3'd5,
        REG_DELTA_2       = 3'd6,
        REG_DELTA_3       = 3'd7
    } reg_idx_t;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [IsoW-1:0]                   isotope_count;
        logic [NumSlots-1:0][ProbW-1:0]    prob;
        logic [NumSlots-1:0][DeltaW-1:0]   delta;
    } cfg_t;

    // one finished result
    typedef struct packed {
        logic [NumSlots-1:0][CountW-1:0]   count;
        logic [ExactW-1:0]                 exact_shift;
        logic [NomW-1:0]                   nominal_shift;
    } result_t;

    // delta rounded half up to whole daltons
    function automatic logic [RoundW-1:0] round_delta(input logic [DeltaW-1:0] d);
        logic [DeltaW:0] s;
        s = {1'b0, d} + ((DeltaW + 1)'(1) << (FracBits - 1));
        return s[DeltaW:FracBits];
    endfunction

endpackage

// ----- sv/multinomial_mode_isotope_shift_unit.sv -----
// ----------------------------------------------------------------------------
// multinomial_mode_isotope_shift_unit
// Modal isotope-count vector of a multinomial distribution and its mass shift.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one atom count per transaction; m_ channel returns the
//   modal counts of up to four isotopes with the exact and nominal mass
//   shifts. Probabilities and deltas are set through the APB port while the
//   block is idle; the block itself does not enforce this.
//   An item holds up to 4095 atoms over up to four isotopes. Its run time is
//   set by the single shared 28x13 multiplier: each comparison of two
//   isotopes is two products, and each shift term is two more.
//   s_tready is high only while the sequencer is idle; one item is in work
//   at a time.
//   The finished result sits in an output register, so a new item can be
//   accepted while m_tready holds it stalled; a second result then waits in
//   the sequencer until the register frees.
//   Reset (aresetn low, synchronous) empties the output register, returns the
//   sequencer to idle and loads the register defaults (two isotopes, prob_0
//   of one, everything else zero).
// ----------------------------------------------------------------------------
module multinomial_mode_isotope_shift_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // atom_count [11:0]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mmis_pkg::SDataW-1:0]      s_tdata,
    // count_0 [11:0], count_1 [23:12], count_2 [35:24], count_3 [47:36],
    // exact_shift [87:48], nominal_shift [103:88]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mmis_pkg::MDataW-1:0]      m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmis_pkg::CfgAddrW-1:0]    paddr,
    input  logic [mmis_pkg::CfgDataW-1:0]    pwdata,
    output logic [mmis_pkg::CfgDataW-1:0]    prdata,
    output logic                             pready
);
    import mmis_pkg::*;

    cfg_t              cfg;
    result_t           core_result;
    logic              core_idle;
    logic              core_done;
    logic              out_free;
    logic              out_vld_reg, out_vld_next;
    logic [MDataW-1:0] out_data_reg, out_data_next;

    // configuration registers
    mmis_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer with shared multiplier
    mmis_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .start      (s_tvalid && s_tready),
        .atom_count (s_tdata[AtomW-1:0]),
        .idle       (core_idle),
        .done_valid (core_done),
        .done_take  (out_free),
        .result     (core_result)
    );

    assign s_tready = core_idle;
    assign out_free = !out_vld_reg || m_tready;

    // output register
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (out_free) begin
            out_vld_next = core_done;
            if (core_done) begin
                out_data_next = {core_result.nominal_shift,
                                 core_result.exact_shift,
                                 core_result.count[3],
                                 core_result.count[2],
                                 core_result.count[1],
                                 core_result.count[0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sv/mmis_regs.sv -----
// ----------------------------------------------------------------------------
// mmis_regs
// APB register file holding isotope count, probabilities and mass deltas.
// ----------------------------------------------------------------------------
module mmis_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [mmis_pkg::CfgAddrW-1:0] paddr,
    input  logic [mmis_pkg::CfgDataW-1:0] pwdata,
    output logic [mmis_pkg::CfgDataW-1:0] prdata,
    output logic                      pready,
    output mmis_pkg::cfg_t            cfg
);
    import mmis_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[CfgAddrW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.isotope_count <= IsoCountReset;
            cfg_reg.prob          <= {{((NumSlots - 1) * ProbW){1'b0}}, ProbOne};
            cfg_reg.delta         <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ISOTOPE_COUNT: cfg_reg.isotope_count <= pwdata[IsoW-1:0];
                REG_PROB_0:        cfg_reg.prob[0]       <= pwdata[ProbW-1:0];
                REG_PROB_1:        cfg_reg.prob[1]       <= pwdata[ProbW-1:0];
                REG_PROB_2:        cfg_reg.prob[2]       <= pwdata[ProbW-1:0];
                REG_PROB_3:        cfg_reg.prob[3]       <= pwdata[ProbW-1:0];
                REG_DELTA_1:       cfg_reg.delta[1]      <= pwdata[DeltaW-1:0];
                REG_DELTA_2:       cfg_reg.delta[2]      <= pwdata[DeltaW-1:0];
                REG_DELTA_3:       cfg_reg.delta[3]      <= pwdata[DeltaW-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_ISOTOPE_COUNT: prdata = CfgDataW'(cfg_reg.isotope_count);
            REG_PROB_0:        prdata = CfgDataW'(cfg_reg.prob[0]);
            REG_PROB_1:        prdata = CfgDataW'(cfg_reg.prob[1]);
            REG_PROB_2:        prdata = CfgDataW'(cfg_reg.prob[2]);
            REG_PROB_3:        prdata = CfgDataW'(cfg_reg.prob[3]);
            REG_DELTA_1:       prdata = CfgDataW'(cfg_reg.delta[1]);
            REG_DELTA_2:       prdata = CfgDataW'(cfg_reg.delta[2]);
            REG_DELTA_3:       prdata = CfgDataW'(cfg_reg.delta[3]);
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- sv/mmis_core.sv -----
// ----------------------------------------------------------------------------
// mmis_core
// Sequencer around one shared multiplier: greedy atom placement by
// cross-multiplied comparison, then mass shift accumulation.
// ----------------------------------------------------------------------------
module mmis_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mmis_pkg::cfg_t             cfg,
    input  logic                       start,
    input  logic [mmis_pkg::AtomW-1:0] atom_count,
    output logic                       idle,
    output logic                       done_valid,
    input  logic                       done_take,
    output mmis_pkg::result_t          result
);
    import mmis_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PICK  = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_SUM_X = 6'b001000,
        ST_SUM_N = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [AtomW-1:0]                atoms_reg, atoms_next;
    logic [IsoW-1:0]                 n_reg, n_next;
    logic [IdxW-1:0]                 idx_reg, idx_next;
    logic                            best_vld_reg, best_vld_next;
    logic [IdxW-1:0]                 best_idx_reg, best_idx_next;
    logic [ProbW-1:0]                best_prob_reg, best_prob_next;
    logic [CountW-1:0]               best_cnt_reg, best_cnt_next;
    logic [NumSlots-1:0][CountW-1:0] cnt_reg, cnt_next;
    logic [KeyW-1:0]                 lhs_reg, lhs_next;
    logic [ExactAccW-1:0]            exact_reg, exact_next;
    logic [NomAccW-1:0]              nom_reg, nom_next;

    logic [IsoW-1:0]   n_sat;
    logic [ProbW-1:0]  cur_prob;
    logic [CountW-1:0] cur_cnt;
    logic [DeltaW-1:0] cur_delta;
    logic              is_last;
    logic [MulAW-1:0]  mul_a;
    logic [MulBW-1:0]  mul_b;
    logic [ProdW-1:0]  product;

    // candidate under test
    assign cur_prob  = cfg.prob[idx_reg];
    assign cur_cnt   = cnt_reg[idx_reg];
    assign cur_delta = cfg.delta[idx_reg];
    assign is_last   = ({1'b0, idx_reg} == (n_reg - IsoW'(1)));
    assign n_sat     = (cfg.isotope_count > IsoW'(NumSlots)) ? IsoW'(NumSlots)
                                                               : cfg.isotope_count;

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_PICK: begin
                mul_a = MulAW'(cur_prob);
                mul_b = {1'b0, best_cnt_reg} + MulBW'(1);
            end
            ST_CMP: begin
                mul_a = MulAW'(best_prob_reg);
                mul_b = {1'b0, cur_cnt} + MulBW'(1);
            end
            ST_SUM_X: begin
                mul_a = cur_delta;
                mul_b = {1'b0, cur_cnt};
            end
            ST_SUM_N: begin
                mul_a = MulAW'(round_delta(cur_delta));
                mul_b = {1'b0, cur_cnt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = ProdW'(mul_a) * ProdW'(mul_b);

    // sequencer
    always_comb begin
        logic advance;
        logic alloc_end;
        logic nb_vld;
        logic [IdxW-1:0]   nb_idx;
        logic [ProbW-1:0]  nb_prob;
        logic [CountW-1:0] nb_cnt;

        state_next     = state_reg;
        atoms_next     = atoms_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_prob_next = best_prob_reg;
        best_cnt_next  = best_cnt_reg;
        cnt_next       = cnt_reg;
        lhs_next       = lhs_reg;
        exact_next     = exact_reg;
        nom_next       = nom_reg;

        advance   = 1'b0;
        alloc_end = 1'b0;
        nb_vld    = best_vld_reg;
        nb_idx    = best_idx_reg;
        nb_prob   = best_prob_reg;
        nb_cnt    = best_cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    atoms_next    = atom_count;
                    n_next        = n_sat;
                    idx_next      = '0;
                    best_vld_next = 1'b0;
                    cnt_next      = '0;
                    exact_next    = '0;
                    nom_next      = '0;
                    if (atom_count == '0 || n_sat == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_PICK;
                    end
                end
            end
            // zero probability skips, first live isotope becomes best,
            // otherwise form p_i * (count_best + 1)
            ST_PICK: begin
                if (cur_prob == '0) begin
                    advance = 1'b1;
                end else if (!best_vld_reg) begin
                    nb_vld  = 1'b1;
                    nb_idx  = idx_reg;
                    nb_prob = cur_prob;
                    nb_cnt  = cur_cnt;
                    advance = 1'b1;
                end else begin
                    lhs_next   = product[KeyW-1:0];
                    state_next = ST_CMP;
                end
            end
            // strict greater replaces, so ties keep the lower index
            ST_CMP: begin
                if (lhs_reg > product[KeyW-1:0]) begin
                    nb_vld  = 1'b1;
                    nb_idx  = idx_reg;
                    nb_prob = cur_prob;
                    nb_cnt  = cur_cnt;
                end
                advance = 1'b1;
            end
            ST_SUM_X: begin
                exact_next = exact_reg + ExactAccW'(product);
                state_next = ST_SUM_N;
            end
            ST_SUM_N: begin
                nom_next = nom_reg + product[NomAccW-1:0];
                if (is_last) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + IdxW'(1);
                    state_next = ST_SUM_X;
                end
            end
            ST_DONE: begin
                if (done_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // end of a candidate: next candidate, or place the atom
        if (advance) begin
            best_vld_next  = nb_vld;
            best_idx_next  = nb_idx;
            best_prob_next = nb_prob;
            best_cnt_next  = nb_cnt;
            if (!is_last) begin
                idx_next   = idx_reg + IdxW'(1);
                state_next = ST_PICK;
            end else if (!nb_vld) begin
                alloc_end = 1'b1;
            end else begin
                cnt_next[nb_idx] = cnt_reg[nb_idx] + CountW'(1);
                atoms_next       = atoms_reg - AtomW'(1);
                if (atoms_reg == AtomW'(1)) begin
                    alloc_end = 1'b1;
                end else begin
                    idx_next      = '0;
                    best_vld_next = 1'b0;
                    state_next    = ST_PICK;
                end
            end
        end

        // allocation finished, shifts over isotopes one and up
        if (alloc_end) begin
            if (n_reg > IsoW'(1)) begin
                idx_next   = IdxW'(1);
                state_next = ST_SUM_X;
            end else begin
                state_next = ST_DONE;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            best_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            best_vld_reg <= best_vld_next;
        end
    end

    // datapath state
    always_ff @(posedge aclk) begin
        atoms_reg     <= atoms_next;
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        best_idx_reg  <= best_idx_next;
        best_prob_reg <= best_prob_next;
        best_cnt_reg  <= best_cnt_next;
        cnt_reg       <= cnt_next;
        lhs_reg       <= lhs_next;
        exact_reg     <= exact_next;
        nom_reg       <= nom_next;
    end

    // result with saturation
    assign idle                 = (state_reg == ST_IDLE);
    assign done_valid           = (state_reg == ST_DONE);
    assign result.count         = cnt_reg;
    assign result.exact_shift   = (|exact_reg[ExactAccW-1:ExactW]) ? {ExactW{1'b1}}
                                                                   : exact_reg[ExactW-1:0];
    assign result.nominal_shift = (|nom_reg[NomAccW-1:NomW]) ? {NomW{1'b1}}
                                                             : nom_reg[NomW-1:0];

endmodule
